// File: design/sci_pkg.sv
package sci_pkg;

  // Field and sample widths
  localparam int ANGLE_W         = 24;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int SAMPLE_BITS     = 16;
  localparam int TABLE_POINTS    = 361;

  // Whole degrees in one turn and the width of a degree index
  localparam int FULL_DEG = TABLE_POINTS - 1;
  localparam int DEG_W    = $clog2(FULL_DEG);

  // Integer part of the angle and its offset to a nonnegative value
  localparam int INT_W  = ANGLE_W - ANGLE_FRAC_BITS;
  localparam int OFFSET = ((2 ** (INT_W - 1) + FULL_DEG - 1) / FULL_DEG) * FULL_DEG;
  localparam int U_W    = INT_W + 1;

  // Reciprocal of a full turn for the quotient estimate
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (2 ** RECIP_SHIFT) / FULL_DEG;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int Q_W         = $clog2((2 ** U_W) / FULL_DEG + 1);

  // Interpolation product width: unsigned fraction times signed difference
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + ANGLE_FRAC_BITS + 1;

  // Quarter of the sine wave, round(sin(k deg) * 32767) for k = 0..90
  localparam int QW_POINTS = FULL_DEG / 4 + 1;
  localparam int QW_IDX_W  = $clog2(QW_POINTS);
  localparam logic [SAMPLE_BITS-2:0] QUARTER_WAVE [0:QW_POINTS-1] = '{
    15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
    15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
    15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
    15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14364, 15'd14876,
    15'd15383, 15'd15886, 15'd16384, 15'd16876, 15'd17364, 15'd17846, 15'd18323,
    15'd18794, 15'd19260, 15'd19720, 15'd20173, 15'd20621, 15'd21062, 15'd21497,
    15'd21925, 15'd22347, 15'd22762, 15'd23170, 15'd23571, 15'd23964, 15'd24351,
    15'd24730, 15'd25101, 15'd25465, 15'd25821, 15'd26169, 15'd26509, 15'd26841,
    15'd27165, 15'd27481, 15'd27788, 15'd28087, 15'd28377, 15'd28659, 15'd28932,
    15'd29196, 15'd29451, 15'd29697, 15'd29934, 15'd30162, 15'd30381, 15'd30591,
    15'd30791, 15'd30982, 15'd31163, 15'd31335, 15'd31498, 15'd31650, 15'd31794,
    15'd31927, 15'd32051, 15'd32165, 15'd32269, 15'd32364, 15'd32448, 15'd32523,
    15'd32587, 15'd32642, 15'd32687, 15'd32722, 15'd32747, 15'd32762, 15'd32767
  };

  // Reduced angle handed from the reduction pipe to the table lookup
  typedef struct packed {
    logic [DEG_W-1:0]           deg;
    logic [ANGLE_FRAC_BITS-1:0] frac;
  } deg_frac_t;

  // Sine of a whole degree in [0, 360) by quarter-wave symmetry
  function automatic logic signed [SAMPLE_BITS-1:0] sine_entry(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0]       idx;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;
    if (d <= DEG_W'(FULL_DEG / 4)) begin
      idx = d;
      neg = 1'b0;
    end else if (d <= DEG_W'(FULL_DEG / 2)) begin
      idx = DEG_W'(FULL_DEG / 2) - d;
      neg = 1'b0;
    end else if (d <= DEG_W'(3 * FULL_DEG / 4)) begin
      idx = d - DEG_W'(FULL_DEG / 2);
      neg = 1'b1;
    end else begin
      idx = DEG_W'(FULL_DEG) - d;
      neg = 1'b1;
    end
    mag = {1'b0, QUARTER_WAVE[idx[QW_IDX_W-1:0]]};
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

// File: design/sci_sine_rom.sv
module sci_sine_rom (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic [sci_pkg::DEG_W-1:0]                addr_a,
  input  logic [sci_pkg::DEG_W-1:0]                addr_b,
  output logic signed [sci_pkg::SAMPLE_BITS-1:0]   rd_data_a,
  output logic signed [sci_pkg::SAMPLE_BITS-1:0]   rd_data_b
);

  logic signed [sci_pkg::SAMPLE_BITS-1:0] rd_data_a_r;
  logic signed [sci_pkg::SAMPLE_BITS-1:0] rd_data_b_r;

  // Two synchronous read ports, held while the stage stalls
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_a_r <= sci_pkg::sine_entry(addr_a);
      rd_data_b_r <= sci_pkg::sine_entry(addr_b);
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// File: design/sci_reduce.sv
module sci_reduce (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [sci_pkg::ANGLE_W-1:0]     in_angle,
  output logic                            in_ready,
  input  logic                            nxt_en,
  output logic                            stage_vld,
  output sci_pkg::deg_frac_t              stage_data
);

  localparam int FR = sci_pkg::ANGLE_FRAC_BITS;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic [sci_pkg::U_W-1:0]   u1_r, u2_r;
  logic [FR-1:0]             f1_r, f2_r, f3_r;
  logic [sci_pkg::Q_W-1:0]   q2_r;
  logic [sci_pkg::DEG_W-1:0] deg3_r;

  logic [sci_pkg::U_W-1:0]             ext;
  logic [sci_pkg::U_W-1:0]             u_nxt;
  logic [sci_pkg::U_W+sci_pkg::RECIP_W-1:0] qprod;
  logic [sci_pkg::Q_W-1:0]             q_nxt;
  logic [sci_pkg::U_W-1:0]             rem;
  logic [sci_pkg::DEG_W-1:0]           deg_nxt;

  // Stage enables: a stage moves when empty or when the next one moves
  assign en3      = !v3_r || nxt_en;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Offset the signed whole degrees to a nonnegative multiple-of-turn shift
  assign ext   = {in_angle[sci_pkg::ANGLE_W-1], in_angle[sci_pkg::ANGLE_W-1:FR]};
  assign u_nxt = ext + sci_pkg::U_W'(sci_pkg::OFFSET);

  // Quotient estimate by reciprocal, low by at most one
  assign qprod = u1_r * sci_pkg::RECIP_W'(sci_pkg::RECIP);
  assign q_nxt = qprod[sci_pkg::RECIP_SHIFT +: sci_pkg::Q_W];

  // Remainder with one correction step
  assign rem     = u2_r - sci_pkg::U_W'(q2_r * sci_pkg::FULL_DEG);
  assign deg_nxt = (rem >= sci_pkg::U_W'(sci_pkg::FULL_DEG))
                   ? sci_pkg::DEG_W'(rem - sci_pkg::U_W'(sci_pkg::FULL_DEG))
                   : sci_pkg::DEG_W'(rem);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en1) begin
      u1_r <= u_nxt;
      f1_r <= in_angle[FR-1:0];
    end
    if (en2) begin
      u2_r <= u1_r;
      q2_r <= q_nxt;
      f2_r <= f1_r;
    end
    if (en3) begin
      deg3_r <= deg_nxt;
      f3_r   <= f2_r;
    end
  end

  assign stage_vld       = v3_r;
  assign stage_data.deg  = deg3_r;
  assign stage_data.frac = f3_r;

  // The reduced degree always lies inside one turn
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (deg3_r < sci_pkg::DEG_W'(sci_pkg::FULL_DEG)))
    else $error("reduced degree out of range");

  // The quotient estimate is never off by more than one
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (rem < sci_pkg::U_W'(2 * sci_pkg::FULL_DEG)))
    else $error("quotient estimate off by more than one");

endmodule

// File: design/sine_cosine_interpolator.sv
// Sine and cosine of an angle in degrees by table lookup and linear interpolation.
// Input channel in_*: one transaction carries a signed angle in degrees with
// 8 fraction bits. It is reduced modulo 360, the whole degree picks two adjacent
// entries of a sine table and the fraction interpolates between them.
// Output channel out_*: one transaction per input carries sine and cosine, Q1.15.
// There are six register stages (3 reduction stages, one registered table read, one
// multiply stage, one output register); the first one loads at the accepting edge
// and the last one drives out_tvalid.
// Throughput: one transaction per cycle while the receiver does not stall; each stage
// holds one item and the table reads are four registered ports of two sine ROMs.
// Reset (rst_n low, synchronous) empties the pipeline by clearing the valid bits; the payload registers are not reset.
// When the receiver stalls, out_tdata holds, bubbles in the pipe still fill up,
// and in_tready falls only once every stage is occupied.
module sine_cosine_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] angle_deg
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] sine_value, [31:16] cosine_value
);

  localparam int SW = sci_pkg::SAMPLE_BITS;
  localparam int FR = sci_pkg::ANGLE_FRAC_BITS;
  localparam int DW = sci_pkg::DEG_W;

  logic en4, en5, en6;
  logic v3, v4_r, v5_r, v6_r;
  sci_pkg::deg_frac_t s3;

  logic [DW-1:0] a_s0, a_s1, a_c0, a_c1;
  logic signed [SW-1:0] sin_lo, sin_hi, cos_lo, cos_hi;
  logic [FR-1:0] f4_r;

  logic signed [FR:0]                  frac_s;
  logic signed [sci_pkg::DIFF_W-1:0]   dif_s, dif_c;
  logic signed [sci_pkg::PROD_W-1:0]   prod_s_nxt, prod_c_nxt;
  logic signed [sci_pkg::PROD_W-1:0]   prod_s_r, prod_c_r;
  logic signed [SW-1:0]                lo_s_r, lo_c_r;
  logic signed [sci_pkg::PROD_W-1:0]   sh_s, sh_c;
  logic signed [SW-1:0]                sin_nxt, cos_nxt;
  logic [31:0]                         out_tdata_r;

  // Stage enables from the output register back
  assign en6 = !v6_r || out_tready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;

  // Angle reduction to whole degree and fraction
  sci_reduce u_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_angle   (in_tdata[sci_pkg::ANGLE_W-1:0]),
    .in_ready   (in_tready),
    .nxt_en     (en4),
    .stage_vld  (v3),
    .stage_data (s3)
  );

  // Table addresses: cosine is sine shifted by a quarter turn, wrapped
  assign a_s0 = s3.deg;
  assign a_s1 = (s3.deg == DW'(sci_pkg::FULL_DEG - 1)) ? '0 : s3.deg + DW'(1);
  assign a_c0 = (s3.deg >= DW'(3 * sci_pkg::FULL_DEG / 4))
                ? s3.deg - DW'(3 * sci_pkg::FULL_DEG / 4)
                : s3.deg + DW'(sci_pkg::FULL_DEG / 4);
  assign a_c1 = (s3.deg >= DW'(3 * sci_pkg::FULL_DEG / 4 - 1))
                ? s3.deg - DW'(3 * sci_pkg::FULL_DEG / 4 - 1)
                : s3.deg + DW'(sci_pkg::FULL_DEG / 4 + 1);

  sci_sine_rom u_rom_sin (
    .clk       (clk),
    .en        (en4),
    .addr_a    (a_s0),
    .addr_b    (a_s1),
    .rd_data_a (sin_lo),
    .rd_data_b (sin_hi)
  );

  sci_sine_rom u_rom_cos (
    .clk       (clk),
    .en        (en4),
    .addr_a    (a_c0),
    .addr_b    (a_c1),
    .rd_data_a (cos_lo),
    .rd_data_b (cos_hi)
  );

  // Fraction times difference of adjacent entries
  assign frac_s     = $signed({1'b0, f4_r});
  assign dif_s      = sci_pkg::DIFF_W'(sin_hi) - sci_pkg::DIFF_W'(sin_lo);
  assign dif_c      = sci_pkg::DIFF_W'(cos_hi) - sci_pkg::DIFF_W'(cos_lo);
  assign prod_s_nxt = frac_s * dif_s;
  assign prod_c_nxt = frac_s * dif_c;

  // Floor shift and add to the lower entry
  assign sh_s    = prod_s_r >>> FR;
  assign sh_c    = prod_c_r >>> FR;
  assign sin_nxt = lo_s_r + SW'(sh_s);
  assign cos_nxt = lo_c_r + SW'(sh_c);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) v4_r <= v3;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en4) f4_r <= s3.frac;
    if (en5) begin
      prod_s_r <= prod_s_nxt;
      prod_c_r <= prod_c_nxt;
      lo_s_r   <= sin_lo;
      lo_c_r   <= cos_lo;
    end
    if (en6) out_tdata_r <= {cos_nxt, sin_nxt};
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = out_tdata_r;

  // Interpolated results never reach the most negative code
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] != 16'h8000 && out_tdata[31:16] != 16'h8000))
    else $error("interpolated sample out of range");

  // Table addresses stay inside one turn whenever a lookup is issued
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v3 && en4) |-> (a_s1 < DW'(sci_pkg::FULL_DEG) && a_c0 < DW'(sci_pkg::FULL_DEG)
                     && a_c1 < DW'(sci_pkg::FULL_DEG)))
    else $error("table address out of range");

endmodule

// File: test/sine_cosine_interpolator_tb.sv
`timescale 1ns / 100ps

module sine_cosine_interpolator_tb;

  localparam int FRAC_BITS     = 8;
  localparam int FRAC_MASK     = (1 << FRAC_BITS) - 1;
  localparam int TURN_FIXED    = 360 << FRAC_BITS;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_LIMIT  = 10;

  // One result transaction: sine in the low half, cosine in the high half
  typedef struct packed {
    logic [15:0] cosine;
    logic [15:0] sine;
  } sincos_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [23:0] angle_deg
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [15:0] sine_value, [31:16] cosine_value

  // round(sin(k deg) * 32767), k = 0..90
  int quarter_sine [0:90] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14364, 14876, 15383, 15886,
    16384, 16876, 17364, 17846, 18323, 18794, 19260, 19720, 20173, 20621,
    21062, 21497, 21925, 22347, 22762, 23170, 23571, 23964, 24351, 24730,
    25101, 25465, 25821, 26169, 26509, 26841, 27165, 27481, 27788, 28087,
    28377, 28659, 28932, 29196, 29451, 29697, 29934, 30162, 30381, 30591,
    30791, 30982, 31163, 31335, 31498, 31650, 31794, 31927, 32051, 32165,
    32269, 32364, 32448, 32523, 32587, 32642, 32687, 32722, 32747, 32762,
    32767
  };

  sincos_t pending_sincos [$];
  int      angles_sent;
  int      results_checked;
  int      mismatch_count;
  int      quiet_cycles;
  logic    idle_off;

  sine_cosine_interpolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Sine of a whole degree by quarter-wave symmetry, degree taken modulo 360
  function automatic int whole_degree_sine(input int d);
    int m;
    m = d % 360;
    if (m <= 90) return quarter_sine[m];
    else if (m <= 180) return quarter_sine[180 - m];
    else if (m <= 270) return -quarter_sine[m - 180];
    else return -quarter_sine[360 - m];
  endfunction

  // Interpolate between two entries, product shifted right with floor
  function automatic int lerp_sample(input int lo, input int hi, input int frac);
    return lo + ((frac * (hi - lo)) >>> FRAC_BITS);
  endfunction

  // Expected sine and cosine of a 24-bit signed angle
  function automatic sincos_t sin_cos_of(input logic [23:0] angle);
    sincos_t res;
    int      a;
    int      r;
    int      d;
    int      f;
    a = {{8{angle[23]}}, angle};
    r = a % TURN_FIXED;
    if (r < 0) r += TURN_FIXED;
    d = r >> FRAC_BITS;
    f = r & FRAC_MASK;
    res.sine   = 16'(lerp_sample(whole_degree_sine(d), whole_degree_sine(d + 1), f));
    res.cosine = 16'(lerp_sample(whole_degree_sine(d + 90), whole_degree_sine(d + 91), f));
    return res;
  endfunction

  function automatic logic [23:0] to_angle(input int whole, input int frac);
    return 24'((whole << FRAC_BITS) + frac);
  endfunction

  // Mostly short gaps, a few long ones, none while idling is switched off
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(99);
    if (idle_off || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Send one angle: optional gap, then hold valid until the handshake
  task automatic send_angle(input logic [23:0] angle);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= angle;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    angles_sent++;
  endtask

  // Field extremes, single-bit corners and alternating bit patterns
  task automatic test_extremes();
    logic [23:0] corner [10] = '{
      24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
      24'h0000FF, 24'h7FFF00, 24'h800001, 24'hAAAAAA, 24'h555555
    };
    foreach (corner[i]) send_angle(corner[i]);
  endtask

  // Quadrant edges, the exact half at thirty degrees, wraps and negative angles
  task automatic test_special_angles();
    send_angle(to_angle(30, 0));
    send_angle(to_angle(29, 128));
    send_angle(to_angle(-1, 128));
    send_angle(to_angle(89, 255));
    send_angle(to_angle(90, 0));
    send_angle(to_angle(179, 200));
    send_angle(to_angle(180, 0));
    send_angle(to_angle(269, 64));
    send_angle(to_angle(270, 0));
    send_angle(to_angle(359, 255));
    send_angle(to_angle(360, 0));
    send_angle(to_angle(-360, 0));
    send_angle(to_angle(765, 77));
    send_angle(to_angle(-91, 3));
  endtask

  // Any 24-bit pattern
  task automatic test_random_full_range(input int count);
    repeat (count) send_angle(24'($urandom()));
  endtask

  // Angles within two turns either side of zero, fractions biased to the ends
  task automatic test_random_near_turn(input int count);
    int whole;
    int frac;
    int roll;
    repeat (count) begin
      whole = int'($urandom_range(1440)) - 720;
      roll  = $urandom_range(3);
      case (roll)
        0: frac = 0;
        1: frac = FRAC_MASK;
        default: frac = $urandom_range(FRAC_MASK);
      endcase
      send_angle(to_angle(whole, frac));
    end
  endtask

  // Full-rate stream with both sides idle-free
  task automatic test_back_to_back(input int count);
    idle_off = 1'b1;
    repeat (count) send_angle(24'($urandom()));
    idle_off = 1'b0;
  endtask

  // Receiver: stall at random, ready stretches of random length
  initial begin : receiver
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Record each accepted angle, compare each accepted result with the oldest one
  always @(posedge clk) begin : scoreboard
    sincos_t want;
    sincos_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) pending_sincos.push_back(sin_cos_of(in_tdata));
      if (out_tvalid && out_tready) begin
        got = sincos_t'(out_tdata);
        results_checked++;
        if (pending_sincos.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: sine %0d cosine %0d",
                     $signed(got.sine), $signed(got.cosine));
        end else begin
          want = pending_sincos.pop_front();
          if (got.sine !== want.sine || got.cosine !== want.cosine) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("mismatch: sine exp %0d got %0d, cosine exp %0d got %0d",
                       $signed(want.sine), $signed(got.sine),
                       $signed(want.cosine), $signed(got.cosine));
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("sine_cosine_interpolator_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    angles_sent     = 0;
    results_checked = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    idle_off        = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_special_angles();
    test_random_full_range(300);
    test_random_near_turn(250);
    test_back_to_back(100);
    in_tvalid <= 1'b0;

    // Drain the pipe, then watch for stray results
    while (pending_sincos.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += pending_sincos.size();

    $display("covered %0d angles: field extremes, quadrant edges, wraps, random full range",
             angles_sent);
    $display("checked %0d sine/cosine results, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sine_cosine_interpolator_tb: clean");
    end else begin
      $display("sine_cosine_interpolator_tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/sci_pkg.sv
design/sci_sine_rom.sv
design/sci_reduce.sv
design/sine_cosine_interpolator.sv
test/sine_cosine_interpolator_tb.sv
